[rtl/wpp_pkg.sv]
// ----------------------------------------------------------------------------
// Window placement penalty package
// Shared types, constants and the saturating adder of the penalty scorer.
// ----------------------------------------------------------------------------
package wpp_pkg;

  localparam int COORD_BITS = 20;
  localparam int END_W      = COORD_BITS + 1;
  localparam int TERM_W     = END_W + 1;
  localparam int SUM_W      = 44;
  localparam int ROW_W      = 3;
  localparam int TOTAL_W    = 7;
  localparam int RCNT_W     = 4;

  localparam logic [SUM_W-1:0]  SUM_MAX       = '1;
  localparam logic [RCNT_W-1:0] ROW_COUNT_RST = 4'd8;

  typedef enum logic [1:0] {
    REQ_SET_BOUNDS = 2'd0,
    REQ_ADD_CELL   = 2'd1,
    REQ_EVALUATE   = 2'd2,
    REQ_CLEAR      = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_REPLY
  } state_e;

  typedef struct packed {
    req_e                  req_type;
    logic [ROW_W-1:0]      row_index;
    logic [COORD_BITS-1:0] cell_x;
    logic [COORD_BITS-1:0] cell_width;
    logic [COORD_BITS-1:0] bound_left;
    logic [COORD_BITS-1:0] bound_right;
  } req_t;

  typedef struct packed {
    logic [SUM_W-1:0]   bounds_penalty;
    logic [SUM_W-1:0]   overlap_penalty;
    logic [TOTAL_W-1:0] cell_total;
    logic               cells_dropped;
  } res_t;

  // A cell travelling along the chain, with the overlap it has gathered so far.
  typedef struct packed {
    logic                  valid;
    logic [ROW_W-1:0]      row;
    logic [COORD_BITS-1:0] x;
    logic [END_W-1:0]      ends;
    logic [SUM_W-1:0]      sum;
  } token_t;

  // Sum of two non-negative values, held at the maximum on overflow.
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                               input logic [SUM_W-1:0] amt);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + {1'b0, amt};
    if (s[SUM_W]) begin
      return SUM_MAX;
    end
    return s[SUM_W-1:0];
  endfunction

endpackage

[rtl/wpp_cell.sv]
// ----------------------------------------------------------------------------
// Window placement penalty chain cell
// Holds one placed cell and scores it against every passing token of its row.
// ----------------------------------------------------------------------------
module wpp_cell
  import wpp_pkg::*;
#(
  parameter int CELL_ID = 0,
  parameter int CNT_W   = 7
) (
  input  logic                  clk_i,
  input  logic                  add_i,
  input  logic [CNT_W-1:0]      count_i,
  input  logic [ROW_W-1:0]      row_i,
  input  logic [COORD_BITS-1:0] x_i,
  input  logic [COORD_BITS-1:0] width_i,
  input  logic                  load_i,
  input  logic                  shift_i,
  input  token_t                tok_i,
  output token_t                tok_o
);

  logic [ROW_W-1:0]      row_q;
  logic [COORD_BITS-1:0] x_q;
  logic [END_W-1:0]      end_q;
  token_t                tok_q, tok_d;
  logic                  held;
  logic [END_W-1:0]      term;

  assign held = (CNT_W'(CELL_ID) < count_i);

  always_ff @(posedge clk_i) begin
    if (add_i && (count_i == CNT_W'(CELL_ID))) begin
      row_q <= row_i;
      x_q   <= x_i;
      end_q <= END_W'(x_i) + END_W'(width_i);
    end
  end

  // The passing token's cell was added earlier, so it is the left cell on a tie.
  always_comb begin
    term = '0;
    if (tok_i.x <= x_q) begin
      if (tok_i.ends > END_W'(x_q)) begin
        term = tok_i.ends - END_W'(x_q);
      end
    end else begin
      if (end_q > END_W'(tok_i.x)) begin
        term = end_q - END_W'(tok_i.x);
      end
    end
  end

  always_comb begin
    tok_d = tok_q;
    if (load_i) begin
      tok_d.valid = held;
      tok_d.row   = row_q;
      tok_d.x     = x_q;
      tok_d.ends  = end_q;
      tok_d.sum   = '0;
    end else if (shift_i) begin
      tok_d = tok_i;
      if (tok_i.valid && held && (tok_i.row == row_q)) begin
        tok_d.sum = sat_add(tok_i.sum, SUM_W'(term));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign tok_o = tok_q;

endmodule

[rtl/wpp_bounds.sv]
// ----------------------------------------------------------------------------
// Window placement penalty row bounds
// Row bound table and the out-of-bounds distance of the cell leaving the chain.
// ----------------------------------------------------------------------------
module wpp_bounds
  import wpp_pkg::*;
#(
  parameter int MAX_ROWS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  set_i,
  input  logic [ROW_W-1:0]      row_i,
  input  logic [COORD_BITS-1:0] left_i,
  input  logic [COORD_BITS-1:0] right_i,
  input  logic [RCNT_W-1:0]     row_count_i,
  input  logic                  clr_i,
  input  logic                  en_i,
  input  token_t                tok_i,
  output logic [TERM_W-1:0]     term_o
);

  localparam int IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [COORD_BITS-1:0] left_q  [MAX_ROWS];
  logic [COORD_BITS-1:0] right_q [MAX_ROWS];
  logic [TERM_W-1:0]     term_q, term_d;
  logic [IDX_W-1:0]      wr_idx, rd_idx;
  logic                  bounded;
  logic [COORD_BITS-1:0] lo, hi;
  logic [COORD_BITS-1:0] lterm;
  logic [END_W-1:0]      rterm;

  assign wr_idx = IDX_W'(row_i);
  assign rd_idx = IDX_W'(tok_i.row);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MAX_ROWS; r++) begin
        left_q[r]  <= '0;
        right_q[r] <= '1;
      end
    end else if (set_i && (int'(row_i) < MAX_ROWS)) begin
      left_q[wr_idx]  <= left_i;
      right_q[wr_idx] <= right_i;
    end
  end

  always_comb begin
    bounded = tok_i.valid && (RCNT_W'(tok_i.row) < row_count_i)
              && (int'(tok_i.row) < MAX_ROWS);
    lo      = bounded ? left_q[rd_idx] : '0;
    hi      = bounded ? right_q[rd_idx] : '0;
    lterm   = '0;
    rterm   = '0;
    if (bounded && (tok_i.x < lo)) begin
      lterm = lo - tok_i.x;
    end
    if (bounded && (tok_i.ends > END_W'(hi))) begin
      rterm = tok_i.ends - END_W'(hi);
    end
    term_d = TERM_W'(lterm) + TERM_W'(rterm);
  end

  always_ff @(posedge clk_i) begin
    if (clr_i) begin
      term_q <= '0;
    end else if (en_i) begin
      term_q <= term_d;
    end
  end

  assign term_o = term_q;

endmodule

[rtl/window_placement_penalty.sv]
// ----------------------------------------------------------------------------
// Window placement penalty
// Scores a placement window: out-of-bounds distance and same-row overlap.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low. Set-bounds,
// add-cell and clear requests take effect at that edge and leave busy_o low,
// so one can follow in every cycle. An evaluate request holds busy_o high
// while the stored cells are copied into a travelling token row which shifts
// one place per cycle along the chain of MAX_CELLS cells, so every pair meets
// once, and a flush state then adds the last bounds term. The result shows in
// the reply state with done_o high, and busy_o falls after it. A new evaluate
// is taken only once busy_o has fallen.
// The receiver cannot stall; done_o beats must be taken when they appear.
// The row_count register is written through cfg_valid_i; cfg_ready_o is high
// while busy_o is low, so a write never lands inside an evaluate.
// Reset empties the store, clears the drop flag, sets row_count to eight and
// opens every row bound to the full coordinate range. No clearing pass runs.
// ----------------------------------------------------------------------------
module window_placement_penalty
  import wpp_pkg::*;
#(
  parameter int MAX_CELLS = 64,
  parameter int MAX_ROWS  = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  req_t              req_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [RCNT_W-1:0] cfg_data_i,
  output logic              done_o,
  output res_t              res_o
);

  localparam int CNT_W  = $clog2(MAX_CELLS + 1);
  localparam int STEP_W = $clog2(MAX_CELLS);

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q;
  logic               drop_q;
  logic [RCNT_W-1:0]  row_count_q;
  logic [STEP_W-1:0]  step_q;
  logic [SUM_W-1:0]   ovl_acc_q;
  logic [SUM_W-1:0]   bnd_acc_q;
  logic               accept;
  logic               add_cell;
  logic               eval_go;
  logic               scan;
  logic               last_step;
  logic [TERM_W-1:0]  bnd_term;
  token_t             chain_in  [MAX_CELLS];
  token_t             chain_out [MAX_CELLS];

  assign accept    = start_i && (state_q == ST_IDLE);
  assign add_cell  = accept && (req_i.req_type == REQ_ADD_CELL);
  assign eval_go   = accept && (req_i.req_type == REQ_EVALUATE);
  assign scan      = (state_q == ST_SCAN);
  assign last_step = (step_q == STEP_W'(MAX_CELLS - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (eval_go) state_d = ST_SCAN;
      ST_SCAN:  if (last_step) state_d = ST_FLUSH;
      ST_FLUSH: state_d = ST_REPLY;
      ST_REPLY: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    busy_o      = (state_q != ST_IDLE);
    done_o      = (state_q == ST_REPLY);
    cfg_ready_o = (state_q == ST_IDLE);
    res_o.bounds_penalty  = bnd_acc_q;
    res_o.overlap_penalty = ovl_acc_q;
    res_o.cell_total      = TOTAL_W'(count_q);
    res_o.cells_dropped   = drop_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      drop_q      <= 1'b0;
      row_count_q <= ROW_COUNT_RST;
      step_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        row_count_q <= cfg_data_i;
      end
      if (add_cell) begin
        if (count_q < CNT_W'(MAX_CELLS)) begin
          count_q <= count_q + 1'b1;
        end else begin
          drop_q <= 1'b1;
        end
      end
      if (accept && (req_i.req_type == REQ_CLEAR)) begin
        count_q <= '0;
        drop_q  <= 1'b0;
      end
      if (eval_go) begin
        step_q <= '0;
      end else if (scan) begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  // The token at the far end of the chain leaves with its full overlap sum.
  always_ff @(posedge clk_i) begin
    if (eval_go) begin
      ovl_acc_q <= '0;
      bnd_acc_q <= '0;
    end else if (scan) begin
      ovl_acc_q <= sat_add(ovl_acc_q, chain_out[MAX_CELLS-1].sum);
      bnd_acc_q <= sat_add(bnd_acc_q, SUM_W'(bnd_term));
    end else if (state_q == ST_FLUSH) begin
      bnd_acc_q <= sat_add(bnd_acc_q, SUM_W'(bnd_term));
    end
  end

  for (genvar k = 0; k < MAX_CELLS; k++) begin : g_chain
    if (k == 0) begin : g_head
      assign chain_in[k] = '0;
    end else begin : g_link
      assign chain_in[k] = chain_out[k-1];
    end

    wpp_cell #(
      .CELL_ID (k),
      .CNT_W   (CNT_W)
    ) u_cell (
      .clk_i   (clk_i),
      .add_i   (add_cell),
      .count_i (count_q),
      .row_i   (req_i.row_index),
      .x_i     (req_i.cell_x),
      .width_i (req_i.cell_width),
      .load_i  (eval_go),
      .shift_i (scan),
      .tok_i   (chain_in[k]),
      .tok_o   (chain_out[k])
    );
  end

  wpp_bounds #(
    .MAX_ROWS (MAX_ROWS)
  ) u_bounds (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .set_i       (accept && (req_i.req_type == REQ_SET_BOUNDS)),
    .row_i       (req_i.row_index),
    .left_i      (req_i.bound_left),
    .right_i     (req_i.bound_right),
    .row_count_i (row_count_q),
    .clr_i       (eval_go),
    .en_i        (scan),
    .tok_i       (chain_out[MAX_CELLS-1]),
    .term_o      (bnd_term)
  );

`ifndef SYNTHESIS
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("result beat outside a busy evaluate");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result beat repeated");

  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_go |=> busy_o && (step_q == '0)) else $error("evaluate did not start a scan");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    add_cell && (count_q == CNT_W'(MAX_CELLS)) |=> drop_q && $stable(count_q))
    else $error("full store accepted a cell");
`endif

endmodule
